@@ hdl/tbpd_pkg.sv @@
// Shared types and constants of the touch baseline press detector.
package tbpd_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned CHANNEL_W = 2;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned BASE_W    = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;

  // Shared multiplier: signed 33 x 17 bits
  localparam int unsigned MUL_A_W = BASE_W + 1;
  localparam int unsigned MUL_B_W = FRAC_W + 1;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_WEIGHT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_FRAC = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_FRAC  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_FLR  = 8'd3;

  // Configuration reset values
  localparam logic [FRAC_W-1:0] AVG_WEIGHT_RST   = 16'd66;
  localparam logic [FRAC_W-1:0] TRIGGER_FRAC_RST = 16'd4588;
  localparam logic [FRAC_W-1:0] GLITCH_FRAC_RST  = 16'd13107;
  localparam logic [FRAC_W-1:0] STARTUP_FLR_RST  = 16'd30;

  // Sequencer states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MULW  = 6'b000010,
    ST_ADJ   = 6'b000100,
    ST_MTRIG = 6'b001000,
    ST_MGLT  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  // Operand selection of the shared multiplier
  typedef enum logic [1:0] {
    MUL_WEIGHT = 2'd0,
    MUL_TRIG   = 2'd1,
    MUL_GLITCH = 2'd2
  } mul_sel_e;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     adjust;
    logic     trig_cmp;
    logic     commit;
  } cmd_t;

  // Configuration register set
  typedef struct packed {
    logic [FRAC_W-1:0] avg_weight;
    logic [FRAC_W-1:0] trigger_fraction;
    logic [FRAC_W-1:0] glitch_fraction;
    logic [FRAC_W-1:0] startup_floor;
  } cfg_t;

  // One result item, lowest field last so it packs from bit 0 up
  typedef struct packed {
    logic [SAMPLE_W-1:0]  baseline_int;
    logic                 press_event;
    logic                 touched;
    logic [CHANNEL_W-1:0] out_channel;
  } result_t;

endpackage

@@ hdl/tbpd_ctrl.sv @@
// Sequencer that steps one sample through the shared multiplier.
module tbpd_ctrl
  import tbpd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic ch_valid_i,
  input  logic out_free_i,
  output logic in_ready_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.mul_sel = MUL_WEIGHT;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MULW;
        end
      end
      ST_MULW: begin
        // A channel outside the pad range skips the arithmetic
        if (ch_valid_i) begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MUL_WEIGHT;
          state_d       = ST_ADJ;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_ADJ: begin
        cmd_o.adjust = 1'b1;
        state_d      = ST_MTRIG;
      end
      ST_MTRIG: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_TRIG;
        state_d       = ST_MGLT;
      end
      ST_MGLT: begin
        cmd_o.trig_cmp = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_GLITCH;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        // Wait until the output register can take the result
        if (out_free_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/tbpd_datapath.sv @@
// Per-channel baseline storage, shared multiplier and window compare.
module tbpd_datapath
  import tbpd_pkg::*;
#(
  parameter int NUM_CHANNELS = 3,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  cfg_t                 cfg_i,
  input  logic [CHANNEL_W-1:0] in_channel_i,
  input  logic [SAMPLE_W-1:0]  in_sample_i,
  output logic                 ch_valid_o,
  output result_t              result_o
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
    SAMPLE_W'((32'd1 << SAMPLE_BITS) - 32'd1);

  logic [BASE_W-1:0]    baseline_q [NUM_CHANNELS];
  logic                 pressed_q  [NUM_CHANNELS];

  logic [CHANNEL_W-1:0] ch_q;
  logic [IDX_W-1:0]     idx_q;
  logic                 ch_valid_q;
  logic [BASE_W-1:0]    s_fix_q;
  logic [BASE_W-1:0]    b_old_q;
  logic [BASE_W-1:0]    b_new_q;
  logic signed [MUL_A_W-1:0] diff_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic                 above_q;

  logic [IDX_W-1:0]     in_idx;
  logic                 in_valid_ch;
  logic [BASE_W-1:0]    in_s_fix;
  logic [BASE_W-1:0]    b_rd;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_rnd;
  logic [BASE_W-1:0]    b_avg;
  logic                 startup;
  logic [BASE_W-1:0]    drop;
  logic [PROD_W-3:0]    drop_sh;
  logic                 pos_drop;
  logic                 hit;
  logic                 was_pressed;

  // Decode the incoming item
  always_comb begin
    in_idx      = IDX_W'(in_channel_i);
    in_valid_ch = (32'(in_channel_i) < 32'(NUM_CHANNELS));
    in_s_fix    = {in_sample_i & SAMPLE_MASK, 16'd0};
    b_rd        = in_valid_ch ? baseline_q[in_idx] : '0;
  end

  // Multiplier operand selection
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_WEIGHT: begin
        mul_a = diff_q;
        mul_b = $signed({1'b0, cfg_i.avg_weight});
      end
      MUL_TRIG: begin
        mul_a = $signed({1'b0, b_new_q});
        mul_b = $signed({1'b0, cfg_i.trigger_fraction});
      end
      MUL_GLITCH: begin
        mul_a = $signed({1'b0, b_new_q});
        mul_b = $signed({1'b0, cfg_i.glitch_fraction});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Baseline update: b + round((s - b) * w / 2^16), or a load at start-up
  always_comb begin
    prod_rnd = prod_q + PROD_W'(32768);
    b_avg    = b_old_q + prod_rnd[BASE_W+15:16];
    startup  = (b_old_q < {cfg_i.startup_floor, 16'd0});
  end

  // Drop against the new baseline and the touch window
  always_comb begin
    pos_drop    = (b_new_q > s_fix_q);
    drop        = b_new_q - s_fix_q;
    drop_sh     = {drop, 16'd0};
    was_pressed = ch_valid_q ? pressed_q[idx_q] : 1'b0;
    hit         = ch_valid_q && above_q && (drop_sh < prod_q[PROD_W-3:0]);
  end

  // Working registers of one item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ch_q    <= in_channel_i;
      idx_q   <= in_idx;
      s_fix_q <= in_s_fix;
      b_old_q <= b_rd;
      diff_q  <= $signed({1'b0, in_s_fix}) - $signed({1'b0, b_rd});
    end
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd_i.adjust) begin
      b_new_q <= startup ? s_fix_q : b_avg;
    end
    if (cmd_i.trig_cmp) begin
      above_q <= pos_drop && (drop_sh > prod_q[PROD_W-3:0]);
    end
  end

  // Channel validity is control state for the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_valid_q <= 1'b0;
    end else if (cmd_i.capture) begin
      ch_valid_q <= in_valid_ch;
    end
  end

  // Per-channel state, written back when the result is committed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        baseline_q[k] <= '0;
        pressed_q[k]  <= 1'b0;
      end
    end else if (cmd_i.commit && ch_valid_q) begin
      baseline_q[idx_q] <= b_new_q;
      pressed_q[idx_q]  <= hit;
    end
  end

  // Result of the item in flight
  always_comb begin
    result_o.out_channel  = ch_q;
    result_o.touched      = hit;
    result_o.press_event  = hit && !was_pressed;
    result_o.baseline_int = ch_valid_q ? b_new_q[BASE_W-1:16] : '0;
  end

  assign ch_valid_o = ch_valid_q;

endmodule

@@ hdl/touch_baseline_press_detector.sv @@
// Top level of the capacitive touch baseline press detector.
//
// Usage: each transfer on the s_axis channel carries one pad reading and its
// channel index. The block keeps a Q16.16 running baseline per channel,
// loads it with the reading while it lies below the start-up floor and
// otherwise moves it toward the reading by the averaging weight. The drop
// of the reading below the new baseline is tested against the trigger and
// glitch fractions; exactly one result transfer follows on m_axis per item.
// Configuration registers are written on the cfg channel (always ready); the
// user must write them only while no item is in flight, which the block does
// not enforce. The sequencer captures an item, forms the weight product,
// adjusts the baseline, forms the trigger and glitch products and commits;
// a channel out of range skips the arithmetic. A new item is taken only once
// the last is committed, as three products share one 33 x 17 multiplier.
// Reset clears all baselines and press flags and restores the register
// defaults. When the receiver stalls, the result waits in the output
// register; one more item is taken and held finished until it drains.
module touch_baseline_press_detector
  import tbpd_pkg::*;
#(
  parameter int NUM_CHANNELS = 3,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [FRAC_W-1:0]     cfg_data_i,
  // Input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata: [1:0] channel, [17:2] sample, [23:18] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // Result stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // tdata: [1:0] out_channel, [2] touched, [3] press_event,
  //        [19:4] baseline_int, [23:20] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  cfg_t    cfg_q;
  cmd_t    cmd;
  result_t result;
  result_t out_data_q;
  logic    out_valid_q;
  logic    out_free;
  logic    ch_valid;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.avg_weight       <= AVG_WEIGHT_RST;
      cfg_q.trigger_fraction <= TRIGGER_FRAC_RST;
      cfg_q.glitch_fraction  <= GLITCH_FRAC_RST;
      cfg_q.startup_floor    <= STARTUP_FLR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_AVG_WEIGHT:   cfg_q.avg_weight       <= cfg_data_i;
        CFG_TRIGGER_FRAC: cfg_q.trigger_fraction <= cfg_data_i;
        CFG_GLITCH_FRAC:  cfg_q.glitch_fraction  <= cfg_data_i;
        CFG_STARTUP_FLR:  cfg_q.startup_floor    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The output register is free when empty or drained in this cycle
  assign out_free = !out_valid_q || m_axis_tready_i;

  tbpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .ch_valid_i (ch_valid),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  tbpd_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_i        (cfg_q),
    .in_channel_i (s_axis_tdata_i[CHANNEL_W-1:0]),
    .in_sample_i  (s_axis_tdata_i[CHANNEL_W+SAMPLE_W-1:CHANNEL_W]),
    .ch_valid_o   (ch_valid),
    .result_o     (result)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.commit) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_DATA_W - $bits(result_t))'(0), out_data_q};

  // A press event is only ever reported together with a touch
  a_press_needs_touch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (!out_data_q.press_event || out_data_q.touched))
    else $error("press event without touch");

  // An out-of-range channel gives no touch and a zero baseline
  a_bad_channel_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (32'(out_data_q.out_channel) >= 32'(NUM_CHANNELS)))
    |-> (!out_data_q.touched && (out_data_q.baseline_int == '0)))
    else $error("out-of-range channel produced a nonzero result");

  // After an input transfer the block is busy with that item
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken while an item is in flight");

  // A result is only committed into a free output register
  a_commit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_valid_q || m_axis_tready_i))
    else $error("result would overwrite a pending transfer");

endmodule
